// ===== hw/rtl/modbus_rtu_reply_checker_assert.svh =====
// Assertion macros for the Modbus RTU reply checker.
// Included by the top level, which checks its own logic; needs clk_i and rst_ni in scope.
`ifndef MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH
`define MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH

`ifndef SYNTH
// Clocked check, off while reset is asserted
`define MRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check, also active during reset
`define MRRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MRRC_ASSERT(lbl, prop, msg)
`define MRRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/mrrc_pkg.sv =====
// Shared types and constants for the Modbus RTU reply checker.
// No dependencies; used by mrrc_crc, mrrc_judge and the top level.
package mrrc_pkg;

  localparam int unsigned FrameLen  = 7;
  localparam int unsigned StoreLen  = FrameLen - 1;  // last byte is used on the fly
  localparam int unsigned CrcBytes  = 5;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  FuncRead  = 8'h03;
  localparam logic [7:0]  ExcFlag   = 8'h80;
  localparam logic [7:0]  ByteCount = 8'h02;

  // Input beat kind (cmd)
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_SHORT   = 3'd2,
    ST_ADDR    = 3'd3,
    ST_EXC     = 3'd4,
    ST_FUNC    = 3'd5,
    ST_LEN     = 3'd6,
    ST_CRC     = 3'd7
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  exception_code;
    logic [15:0] distance_tenth_mm;
  } result_t;

endpackage

// ===== hw/rtl/modbus_rtu_reply_checker.sv =====
// Top level of the Modbus RTU reply checker: input register, frame state, result register.
// Depends on mrrc_pkg, mrrc_crc, mrrc_judge and modbus_rtu_reply_checker_assert.svh.
//
//   channel   direction  tdata                         tuser
//   s_axis    in         [7:0] rx_byte                 [1:0] cmd
//   m_axis    out        [7:0] exception_code,         [2:0] status
//                        [23:8] distance_tenth_mm
//   cfg       in         cfg_wdata_i [7:0] slave_address, written when cfg_we_i
//
// One beat per cycle sustained while the result register is free; an input beat passes
// the input register, then frame state update and verdict into the result register.
// CRC update and verdict are combinational between these registers.
// Reset clears the count, the CRC and both valid flags and sets the slave address to 8'h01;
// stored bytes are not reset. A stalled result holds the result register; the input register still takes one beat.
module modbus_rtu_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] exception_code, [23:8] distance_tenth_mm
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam logic [2:0] LastIdx = 3'(mrrc_pkg::StoreLen);
  localparam logic [2:0] CrcLen  = 3'(mrrc_pkg::CrcBytes);

  logic              in_valid_q, in_valid_d;
  mrrc_pkg::cmd_e    in_cmd_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  mrrc_pkg::result_t out_res_q;
  logic [7:0]        slave_addr_q;
  logic [2:0]        cnt_q, cnt_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        frame_q [mrrc_pkg::StoreLen];

  logic              out_free, proc, emit, store;
  logic [15:0]       crc_next;
  mrrc_pkg::result_t judge_res, res;

  logic              idle_ok, beat_start, beat_close;

  // Handshake: the result register frees when empty or taken
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_valid_d      = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= mrrc_pkg::cmd_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'h01;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_wdata_i;
    end
  end

  mrrc_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (in_byte_q),
    .crc_o  (crc_next)
  );

  mrrc_judge u_judge (
    .frame_i      (frame_q),
    .last_byte_i  (in_byte_q),
    .crc_i        (crc_q),
    .slave_addr_i (slave_addr_q),
    .result_o     (judge_res)
  );

  // Frame state update and result selection
  always_comb begin
    cnt_d                 = cnt_q;
    crc_d                 = crc_q;
    emit                  = 1'b0;
    store                 = 1'b0;
    res.status            = mrrc_pkg::ST_TIMEOUT;
    res.exception_code    = 8'h00;
    res.distance_tenth_mm = 16'h0000;
    if (proc) begin
      case (in_cmd_q)
        mrrc_pkg::CMD_BYTE: begin
          if (cnt_q == LastIdx) begin
            emit  = 1'b1;
            res   = judge_res;
            cnt_d = 3'd0;
            crc_d = mrrc_pkg::CrcInit;
          end else begin
            store = 1'b1;
            cnt_d = cnt_q + 3'd1;
            if (cnt_q < CrcLen) begin
              crc_d = crc_next;
            end
          end
        end
        mrrc_pkg::CMD_END: begin
          emit       = 1'b1;
          res.status = (cnt_q == 3'd0) ? mrrc_pkg::ST_TIMEOUT : mrrc_pkg::ST_SHORT;
          cnt_d      = 3'd0;
          crc_d      = mrrc_pkg::CrcInit;
        end
        mrrc_pkg::CMD_START: begin
          cnt_d = 3'd0;
          crc_d = mrrc_pkg::CrcInit;
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      crc_q <= mrrc_pkg::CrcInit;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  // Byte store, written at the current count
  always_ff @(posedge clk_i) begin
    if (store) begin
      frame_q[cnt_q] <= in_byte_q;
    end
  end

  // Result register
  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {out_res_q.distance_tenth_mm, out_res_q.exception_code};

  // Terms used by the checks
  assign idle_ok    = (cnt_q != 3'd0) || (crc_q == mrrc_pkg::CrcInit);
  assign beat_start = proc && (in_cmd_q == mrrc_pkg::CMD_START);
  assign beat_close = proc && ((in_cmd_q == mrrc_pkg::CMD_END) ||
                               (in_cmd_q == mrrc_pkg::CMD_BYTE && cnt_q == LastIdx));

  // Checks
`include "modbus_rtu_reply_checker_assert.svh"

  `MRRC_ASSERT_ALWAYS(a_cnt_range, !rst_ni || cnt_q <= LastIdx, "count beyond frame")
  `MRRC_ASSERT_ALWAYS(a_crc_idle, !rst_ni || idle_ok, "crc not at init with empty frame")
  `MRRC_ASSERT(a_start_clears, beat_start |=> (cnt_q == 3'd0), "start did not clear count")
  `MRRC_ASSERT(a_rise_cause, $rose(out_valid_q) |-> $past(beat_close), "result without a cause")
  `MRRC_ASSERT(a_no_overrun, (s_axis_tready_o && !out_free) |-> !in_valid_q, "input overrun")

endmodule

// ===== hw/rtl/mrrc_crc.sv =====
// Byte-wide CRC-16 update (reflected, polynomial A001).
// Depends on mrrc_pkg for the polynomial.
module mrrc_crc (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  // Eight bit steps of the reflected shift register, unrolled
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrrc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ===== hw/rtl/mrrc_judge.sv =====
// Verdict logic for a complete 7-byte reply: address, function or exception, length, CRC.
// Depends on mrrc_pkg for codes, constants and the result struct.
module mrrc_judge (
  input  logic [7:0]       frame_i [mrrc_pkg::StoreLen],  // bytes 0 to 5
  input  logic [7:0]       last_byte_i,                   // byte 6 (CRC high)
  input  logic [15:0]      crc_i,                         // CRC over bytes 0 to 4
  input  logic [7:0]       slave_addr_i,
  output mrrc_pkg::result_t result_o
);

  logic [15:0] crc_rx;

  // CRC travels low byte first
  assign crc_rx = {last_byte_i, frame_i[5]};

  // Checks in priority order
  always_comb begin
    result_o.status            = mrrc_pkg::ST_OK;
    result_o.exception_code    = 8'h00;
    result_o.distance_tenth_mm = 16'h0000;
    if (frame_i[0] != slave_addr_i) begin
      result_o.status = mrrc_pkg::ST_ADDR;
    end else if (frame_i[1] != mrrc_pkg::FuncRead) begin
      if ((frame_i[1] & mrrc_pkg::ExcFlag) != 8'h00) begin
        result_o.status         = mrrc_pkg::ST_EXC;
        result_o.exception_code = frame_i[2];
      end else begin
        result_o.status = mrrc_pkg::ST_FUNC;
      end
    end else if (frame_i[2] != mrrc_pkg::ByteCount) begin
      result_o.status = mrrc_pkg::ST_LEN;
    end else if (crc_rx != crc_i) begin
      result_o.status = mrrc_pkg::ST_CRC;
    end else begin
      result_o.distance_tenth_mm = {frame_i[3], frame_i[4]};
    end
  end

endmodule
